/* hw/rtl/ttl_expiring_fifo_cache_core_defines.svh */
// Assertion macros used by the TTL cache core.
`ifndef TTL_EXPIRING_FIFO_CACHE_CORE_DEFINES_SVH
`define TTL_EXPIRING_FIFO_CACHE_CORE_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define TTLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define TTLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ttlc_pkg.sv */
// Shared types and constants of the TTL cache.
package ttlc_pkg;

  localparam int unsigned SLOTS = 8;
  localparam int unsigned IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNTW  = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    FUNC_LOOKUP  = 2'd0,
    FUNC_INSERT  = 2'd1,
    FUNC_REPLACE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_INSERT
  } state_e;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] expire;
    logic [15:0] payload;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IDXW-1:0] waddr;
    logic            re;
    logic [IDXW-1:0] raddr;
  } mem_req_t;

endpackage

/* hw/rtl/ttl_expiring_fifo_cache_core.sv */
// Top level of the TTL cache with FIFO replacement.
// A request is taken when start is high and busy is low; busy then stays high until
// the single result beat, which appears on valid_o for exactly one cycle and cannot be
// stalled. Every request first sweeps the live entries (dropping expired ones and packing
// the rest in age order), one entry per cycle through the single read port of the slot
// store. An insert then writes the new entry; into a full cache it first moves every
// entry up by one slot and drops the oldest, and a replace that finds its target first
// moves the entries newer than the removed one up by one slot before it writes the new
// entry.
// A new request may be started in the same cycle as the result beat.
`include "ttl_expiring_fifo_cache_core_defines.svh"

module ttl_expiring_fifo_cache_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [31:0] now_i,
  input  logic [63:0] key_i,
  input  logic [63:0] evict_key_i,
  input  logic [31:0] new_expire_i,
  input  logic [15:0] new_payload_i,
  output logic        valid_o,
  output logic        hit_o,
  output logic [15:0] payload_o,
  output logic [31:0] remaining_ttl_o,
  output logic        evicted_oldest_o,
  output logic        status_o
);

  localparam int unsigned IDXW = ttlc_pkg::IDXW;
  localparam int unsigned CNTW = ttlc_pkg::CNTW;

  ttlc_pkg::state_e state_q, state_d;
  ttlc_pkg::func_e  func_q, func_d;
  logic [31:0]      now_q, now_d;
  logic [63:0]      key_q, key_d;
  logic [63:0]      mkey_q, mkey_d;
  logic [31:0]      nexp_q, nexp_d;
  logic [15:0]      npay_q, npay_d;

  logic [CNTW-1:0]  count_q, count_d;
  logic [IDXW-1:0]  rd_idx_q, rd_idx_d;
  logic [CNTW-1:0]  rd_left_q, rd_left_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDXW-1:0]  wr_idx_q, wr_idx_d;
  logic [CNTW-1:0]  n_q, n_d;
  logic             match_q, match_d;
  logic [IDXW-1:0]  mpos_q, mpos_d;
  logic [31:0]      mexp_q, mexp_d;
  logic [15:0]      mpay_q, mpay_d;
  logic             evict_q, evict_d;

  logic             valid_q, valid_d;
  logic             hit_q, hit_d;
  logic [15:0]      payload_q, payload_d;
  logic [31:0]      ttl_q, ttl_d;
  logic             evicted_q, evicted_d;
  logic             status_q, status_d;

  ttlc_pkg::mem_req_t mem_req;
  ttlc_pkg::entry_t   mem_wdata;
  ttlc_pkg::entry_t   rd_entry;
  logic               expired;
  logic               key_eq;

  ttlc_slot_mem u_slot_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .wdata_i (mem_wdata),
    .rdata_o (rd_entry)
  );

  // Shared compare unit: one entry per cycle.
  assign expired = (rd_entry.expire < now_q);
  assign key_eq  = (rd_entry.key == mkey_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ttlc_pkg::ST_IDLE;
      count_q   <= '0;
      rd_vld_q  <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_vld_q  <= rd_vld_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    now_q     <= now_d;
    key_q     <= key_d;
    mkey_q    <= mkey_d;
    nexp_q    <= nexp_d;
    npay_q    <= npay_d;
    rd_idx_q  <= rd_idx_d;
    rd_left_q <= rd_left_d;
    wr_idx_q  <= wr_idx_d;
    n_q       <= n_d;
    match_q   <= match_d;
    mpos_q    <= mpos_d;
    mexp_q    <= mexp_d;
    mpay_q    <= mpay_d;
    evict_q   <= evict_d;
    hit_q     <= hit_d;
    payload_q <= payload_d;
    ttl_q     <= ttl_d;
    evicted_q <= evicted_d;
    status_q  <= status_d;
  end

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    now_d     = now_q;
    key_d     = key_q;
    mkey_d    = mkey_q;
    nexp_d    = nexp_q;
    npay_d    = npay_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    rd_left_d = rd_left_q;
    rd_vld_d  = 1'b0;
    wr_idx_d  = wr_idx_q;
    n_d       = n_q;
    match_d   = match_q;
    mpos_d    = mpos_q;
    mexp_d    = mexp_q;
    mpay_d    = mpay_q;
    evict_d   = evict_q;
    valid_d   = 1'b0;
    hit_d     = hit_q;
    payload_d = payload_q;
    ttl_d     = ttl_q;
    evicted_d = evicted_q;
    status_d  = status_q;
    mem_req   = '0;
    mem_wdata = rd_entry;

    unique case (state_q) inside
      ttlc_pkg::ST_IDLE: begin
        if (start) begin
          func_d    = ttlc_pkg::func_e'(func_i);
          now_d     = now_i;
          key_d     = key_i;
          mkey_d    = (func_i == ttlc_pkg::FUNC_REPLACE) ? evict_key_i : key_i;
          nexp_d    = new_expire_i;
          npay_d    = new_payload_i;
          rd_idx_d  = IDXW'(ttlc_pkg::SLOTS - 1);
          wr_idx_d  = IDXW'(ttlc_pkg::SLOTS - 1);
          rd_left_d = count_q;
          n_d       = '0;
          match_d   = 1'b0;
          evict_d   = 1'b0;
          state_d   = ttlc_pkg::ST_SCAN;
        end
      end

      ttlc_pkg::ST_SCAN, ttlc_pkg::ST_SHIFT: begin
        // Issue the next read, oldest slot first.
        if (rd_left_q != '0) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_idx_q;
          rd_idx_d      = rd_idx_q - IDXW'(1);
          rd_left_d     = rd_left_q - CNTW'(1);
          rd_vld_d      = 1'b1;
        end
        // Write back surviving entries toward the top slot.
        if (rd_vld_q && ((state_q == ttlc_pkg::ST_SHIFT) || !expired)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = wr_idx_q;
          mem_wdata     = rd_entry;
          wr_idx_d      = wr_idx_q - IDXW'(1);
          if (state_q == ttlc_pkg::ST_SCAN) begin
            n_d = n_q + CNTW'(1);
            // Later survivors are newer: the last match wins.
            if (key_eq) begin
              match_d = 1'b1;
              mpos_d  = wr_idx_q;
              mexp_d  = rd_entry.expire;
              mpay_d  = rd_entry.payload;
            end
          end
        end
        if ((rd_left_q == '0) && !rd_vld_q) begin
          if (state_q == ttlc_pkg::ST_SHIFT) begin
            state_d = ttlc_pkg::ST_INSERT;
          end else begin
            count_d   = n_q;
            hit_d     = 1'b0;
            payload_d = '0;
            ttl_d     = '0;
            evicted_d = 1'b0;
            status_d  = 1'b0;
            unique case (func_q)
              ttlc_pkg::FUNC_LOOKUP: begin
                valid_d = 1'b1;
                state_d = ttlc_pkg::ST_IDLE;
                if (match_q) begin
                  hit_d     = 1'b1;
                  payload_d = mpay_q;
                  ttl_d     = mexp_q - now_q;
                end
              end
              ttlc_pkg::FUNC_INSERT: begin
                if (n_q == CNTW'(ttlc_pkg::SLOTS)) begin
                  // Full: advance every entry one slot and drop the oldest.
                  count_d   = CNTW'(ttlc_pkg::SLOTS - 1);
                  evict_d   = 1'b1;
                  rd_idx_d  = IDXW'(ttlc_pkg::SLOTS - 2);
                  wr_idx_d  = IDXW'(ttlc_pkg::SLOTS - 1);
                  rd_left_d = CNTW'(ttlc_pkg::SLOTS - 1);
                  state_d   = ttlc_pkg::ST_SHIFT;
                end else begin
                  state_d = ttlc_pkg::ST_INSERT;
                end
              end
              ttlc_pkg::FUNC_REPLACE: begin
                if (!match_q) begin
                  status_d = 1'b1;
                  valid_d  = 1'b1;
                  state_d  = ttlc_pkg::ST_IDLE;
                end else begin
                  // Close the gap: move newer entries up over the removed one.
                  count_d   = n_q - CNTW'(1);
                  rd_idx_d  = mpos_q - IDXW'(1);
                  wr_idx_d  = mpos_q;
                  rd_left_d = CNTW'(mpos_q) + n_q - CNTW'(ttlc_pkg::SLOTS);
                  state_d   = ttlc_pkg::ST_SHIFT;
                end
              end
              default: begin
                valid_d = 1'b1;
                state_d = ttlc_pkg::ST_IDLE;
              end
            endcase
          end
        end
      end

      ttlc_pkg::ST_INSERT: begin
        mem_req.we        = 1'b1;
        mem_req.waddr     = IDXW'(ttlc_pkg::SLOTS - 1) - count_q[IDXW-1:0];
        mem_wdata.key     = key_q;
        mem_wdata.expire  = nexp_q;
        mem_wdata.payload = npay_q;
        count_d   = count_q + CNTW'(1);
        hit_d     = 1'b0;
        payload_d = '0;
        ttl_d     = '0;
        evicted_d = evict_q;
        status_d  = 1'b0;
        valid_d   = 1'b1;
        state_d   = ttlc_pkg::ST_IDLE;
      end

      default: begin
        state_d = ttlc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy             = (state_q != ttlc_pkg::ST_IDLE);
  assign valid_o          = valid_q;
  assign hit_o            = hit_q;
  assign payload_o        = payload_q;
  assign remaining_ttl_o  = ttl_q;
  assign evicted_oldest_o = evicted_q;
  assign status_o         = status_q;

  `TTLC_ASSERT(a_count_range, count_q <= CNTW'(ttlc_pkg::SLOTS), "live count exceeds slots")
  `TTLC_ASSERT(a_beat_after_busy, !valid_o || $past(busy), "result beat without a request")
  `TTLC_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")
  `TTLC_ASSERT(a_hit_excl, !(valid_o && hit_o) || (!evicted_oldest_o && !status_o), "hit mixed with insert flags")
  `TTLC_ASSERT(a_evict_full, !(valid_o && evicted_oldest_o) || (count_q == CNTW'(ttlc_pkg::SLOTS)), "eviction left cache not full")

endmodule

/* hw/rtl/ttlc_slot_mem.sv */
// Slot store: one write port, one registered read port.
module ttlc_slot_mem (
  input  logic              clk_i,
  input  ttlc_pkg::mem_req_t req_i,
  input  ttlc_pkg::entry_t  wdata_i,
  output ttlc_pkg::entry_t  rdata_o
);

  ttlc_pkg::entry_t mem_q [ttlc_pkg::SLOTS];
  ttlc_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* verif/tb.sv */
// Self-checking testbench for the TTL cache core: directed table, then random requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam logic [63:0] ALL_ONES_TAG = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned RANDOM_ITEMS = 1420;
  localparam int unsigned BURST_SPAN   = 150;
  localparam int unsigned TAG_POOL     = 12;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 2 * ttlc_pkg::SLOTS + 8;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now;
    logic [63:0] key;
    logic [63:0] evict_key;
    logic [31:0] new_expire;
    logic [15:0] new_payload;
  } cache_req_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] payload;
    logic [31:0] remaining_ttl;
    logic        evicted_oldest;
    logic        status;
  } cache_result_t;

  typedef struct packed {
    cache_req_t    req;
    logic          typed;
    cache_result_t want;
  } script_row_t;

  localparam cache_result_t QUIET = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func_i = 2'd0;
  logic [31:0] now_i = 32'd0;
  logic [63:0] key_i = 64'd0;
  logic [63:0] evict_key_i = 64'd0;
  logic [31:0] new_expire_i = 32'd0;
  logic [15:0] new_payload_i = 16'd0;
  logic        valid_o;
  logic        hit_o;
  logic [15:0] payload_o;
  logic [31:0] remaining_ttl_o;
  logic        evicted_oldest_o;
  logic        status_o;

  ttl_expiring_fifo_cache_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .now_i            (now_i),
    .key_i            (key_i),
    .evict_key_i      (evict_key_i),
    .new_expire_i     (new_expire_i),
    .new_payload_i    (new_payload_i),
    .valid_o          (valid_o),
    .hit_o            (hit_o),
    .payload_o        (payload_o),
    .remaining_ttl_o  (remaining_ttl_o),
    .evicted_oldest_o (evicted_oldest_o),
    .status_o         (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted cache contents, oldest entry in the top slot.
  bit            entry_live   [ttlc_pkg::SLOTS];
  logic [63:0]   entry_tag    [ttlc_pkg::SLOTS];
  logic [31:0]   entry_expiry [ttlc_pkg::SLOTS];
  logic [15:0]   entry_handle [ttlc_pkg::SLOTS];

  cache_result_t awaited_results [$];
  script_row_t   script [$];
  logic [63:0]   tag_pool [TAG_POOL];
  logic [31:0]   wall_clock;
  int unsigned   fault_count = 0;
  int unsigned   quiet_cycles = 0;

  function automatic void relocate(int dst, int src);
    entry_live[dst]   = entry_live[src];
    entry_tag[dst]    = entry_tag[src];
    entry_expiry[dst] = entry_expiry[src];
    entry_handle[dst] = entry_handle[src];
  endfunction

  // Drop stale entries when asked, then pack the survivors to the top in age order.
  function automatic void pack_live(logic [31:0] now, bit prune);
    int w;
    w = ttlc_pkg::SLOTS - 1;
    for (int i = ttlc_pkg::SLOTS - 1; i >= 0; i--) begin
      if (entry_live[i] && !(prune && entry_expiry[i] < now)) begin
        if (w != i) relocate(w, i);
        w--;
      end
    end
    for (int i = w; i >= 0; i--) entry_live[i] = 1'b0;
  endfunction

  function automatic bit store_entry(logic [63:0] tag, logic [31:0] expiry,
                                     logic [15:0] handle);
    bit dropped;
    dropped = 1'b0;
    if (entry_live[0]) begin
      for (int i = ttlc_pkg::SLOTS - 1; i > 0; i--) relocate(i, i - 1);
      entry_live[0] = 1'b0;
      dropped = 1'b1;
    end
    for (int i = ttlc_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!entry_live[i]) begin
        entry_live[i]   = 1'b1;
        entry_tag[i]    = tag;
        entry_expiry[i] = expiry;
        entry_handle[i] = handle;
        break;
      end
    end
    return dropped;
  endfunction

  function automatic int newest_with_tag(logic [63:0] tag);
    for (int i = 0; i < ttlc_pkg::SLOTS; i++)
      if (entry_live[i] && entry_tag[i] == tag) return i;
    return -1;
  endfunction

  function automatic cache_result_t predict_outcome(cache_req_t r);
    cache_result_t res;
    int m;
    res = '0;
    pack_live(r.now, 1'b1);
    case (r.func)
      ttlc_pkg::FUNC_LOOKUP: begin
        m = newest_with_tag(r.key);
        if (m >= 0) begin
          res.hit = 1'b1;
          res.payload = entry_handle[m];
          res.remaining_ttl = entry_expiry[m] - r.now;
        end
      end
      ttlc_pkg::FUNC_INSERT: begin
        res.evicted_oldest = store_entry(r.key, r.new_expire, r.new_payload);
      end
      ttlc_pkg::FUNC_REPLACE: begin
        m = newest_with_tag(r.evict_key);
        if (m < 0) begin
          res.status = 1'b1;
        end else begin
          entry_live[m] = 1'b0;
          pack_live(r.now, 1'b0);
          void'(store_entry(r.key, r.new_expire, r.new_payload));
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [63:0] pick_tag();
    if ($urandom_range(0, 99) < 85) return tag_pool[$urandom_range(0, TAG_POOL - 1)];
    return {$urandom, $urandom};
  endfunction

  // Time mostly creeps forward; now and then it jumps.
  function automatic cache_req_t draw_request();
    cache_req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) wall_clock = wall_clock + 32'($urandom_range(0, 6));
    else if (pick < 90) wall_clock = wall_clock - 32'($urandom_range(0, 50));
    else if (pick < 95) wall_clock = $urandom;
    else wall_clock = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
    r.now = wall_clock;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.func = ttlc_pkg::FUNC_LOOKUP;
    else if (pick < 72) r.func = ttlc_pkg::FUNC_INSERT;
    else if (pick < 94) r.func = ttlc_pkg::FUNC_REPLACE;
    else r.func = FUNC_UNUSED;
    r.key = pick_tag();
    r.evict_key = pick_tag();
    pick = $urandom_range(0, 99);
    if (pick < 80) r.new_expire = r.now + 32'($urandom_range(0, 40));
    else if (pick < 90) r.new_expire = r.now - 32'($urandom_range(1, 20));
    else r.new_expire = $urandom;
    r.new_payload = 16'($urandom);
    return r;
  endfunction

  task automatic issue(cache_req_t r, int unsigned gap, logic typed, cache_result_t want);
    cache_result_t predicted;
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start         <= 1'b1;
    func_i        <= r.func;
    now_i         <= r.now;
    key_i         <= r.key;
    evict_key_i   <= r.evict_key;
    new_expire_i  <= r.new_expire;
    new_payload_i <= r.new_payload;
    do @(posedge clk_i); while (busy);
    predicted = predict_outcome(r);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  // Hold the sender off until every awaited beat is back.
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void report_fault(string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("tb: mismatch: %s", msg);
  endfunction

  always @(posedge clk_i) begin
    cache_result_t want;
    if (rst_ni && valid_o) begin
      if (awaited_results.size() == 0) begin
        report_fault("result beat with nothing awaited");
      end else begin
        want = awaited_results.pop_front();
        if (hit_o !== want.hit || payload_o !== want.payload ||
            remaining_ttl_o !== want.remaining_ttl ||
            evicted_oldest_o !== want.evicted_oldest || status_o !== want.status) begin
          report_fault($sformatf(
            "expected hit %0d payload %h ttl %h evicted %0d status %0d, got %0d %h %h %0d %0d",
            want.hit, want.payload, want.remaining_ttl, want.evicted_oldest, want.status,
            hit_o, payload_o, remaining_ttl_o, evicted_oldest_o, status_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = {$urandom, $urandom};
    wall_clock = 32'd1000;

    // Empty cache: misses, missing replace target, unused code.
    script.push_back('{'{ttlc_pkg::FUNC_LOOKUP, 32'd0, 64'd0, 64'd0, 32'd0, 16'd0}, 1'b1,
                       QUIET});
    script.push_back('{'{ttlc_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, ALL_ONES_TAG, ALL_ONES_TAG,
                         32'hFFFF_FFFF, 16'hFFFF}, 1'b1, QUIET});
    script.push_back('{'{ttlc_pkg::FUNC_REPLACE, 32'd0, 64'h1, ALL_ONES_TAG, 32'd50,
                         16'h0001}, 1'b1, '{1'b0, 16'h0, 32'h0, 1'b0, 1'b1}});
    script.push_back('{'{FUNC_UNUSED, 32'd5, ALL_ONES_TAG, 64'd0, 32'hFFFF_FFFF, 16'hFFFF},
                       1'b1, QUIET});
    // Expiry equal to now is still live with no time left; once now is one past it, it is gone.
    script.push_back('{'{ttlc_pkg::FUNC_INSERT, 32'd0, 64'd0, 64'd0, 32'd0, 16'h0000}, 1'b1,
                       QUIET});
    script.push_back('{'{ttlc_pkg::FUNC_LOOKUP, 32'd0, 64'd0, 64'd0, 32'd0, 16'd0}, 1'b1,
                       '{1'b1, 16'h0000, 32'd0, 1'b0, 1'b0}});
    script.push_back('{'{ttlc_pkg::FUNC_LOOKUP, 32'd1, 64'd0, 64'd0, 32'd0, 16'd0}, 1'b1,
                       QUIET});
    script.push_back('{'{ttlc_pkg::FUNC_INSERT, 32'd100, 64'h1, 64'd0, 32'd200, 16'hFFFF},
                       1'b1, QUIET});
    script.push_back('{'{ttlc_pkg::FUNC_LOOKUP, 32'd100, 64'h1, 64'd0, 32'd0, 16'd0}, 1'b1,
                       '{1'b1, 16'hFFFF, 32'd100, 1'b0, 1'b0}});
    script.push_back('{'{ttlc_pkg::FUNC_LOOKUP, 32'd200, 64'h1, 64'd0, 32'd0, 16'd0}, 1'b1,
                       '{1'b1, 16'hFFFF, 32'd0, 1'b0, 1'b0}});
    script.push_back('{'{ttlc_pkg::FUNC_LOOKUP, 32'd201, 64'h1, 64'd0, 32'd0, 16'd0}, 1'b1,
                       QUIET});
    script.push_back('{'{ttlc_pkg::FUNC_INSERT, 32'd300, ALL_ONES_TAG, 64'd0, 32'hFFFF_FFFF,
                         16'h1234}, 1'b1, QUIET});
    // Insert that is stale on arrival: stored, then dropped by the next request.
    script.push_back('{'{ttlc_pkg::FUNC_INSERT, 32'd300, 64'h5, 64'd0, 32'd10, 16'h0005},
                       1'b1, QUIET});
    script.push_back('{'{ttlc_pkg::FUNC_LOOKUP, 32'd300, 64'h5, 64'd0, 32'd0, 16'd0}, 1'b1,
                       QUIET});
    // Time going backwards.
    script.push_back('{'{ttlc_pkg::FUNC_LOOKUP, 32'd0, ALL_ONES_TAG, 64'd0, 32'd0, 16'd0},
                       1'b1, '{1'b1, 16'h1234, 32'hFFFF_FFFF, 1'b0, 1'b0}});
    for (int k = 0; k < 7; k++)
      script.push_back('{'{ttlc_pkg::FUNC_INSERT, 32'd400, 64'h10 + 64'(k), 64'd0,
                           32'h8000_0000 + 32'(k), 16'h0100 + 16'(k)}, 1'b0, QUIET});
    // Full cache: oldest goes, and the duplicate tag shadows the older one.
    script.push_back('{'{ttlc_pkg::FUNC_INSERT, 32'd400, 64'h10, 64'd0, 32'hFFFF_FFFF,
                         16'hAAAA}, 1'b1, '{1'b0, 16'h0, 32'h0, 1'b1, 1'b0}});
    script.push_back('{'{ttlc_pkg::FUNC_LOOKUP, 32'd400, 64'h10, 64'd0, 32'd0, 16'd0}, 1'b0,
                       QUIET});
    script.push_back('{'{ttlc_pkg::FUNC_REPLACE, 32'd400, 64'h20, 64'h10, 32'h9000_0000,
                         16'h5555}, 1'b0, QUIET});
    script.push_back('{'{ttlc_pkg::FUNC_LOOKUP, 32'd400, 64'h10, 64'd0, 32'd0, 16'd0}, 1'b0,
                       QUIET});
    script.push_back('{'{FUNC_UNUSED, 32'hFFFF_FFFF, 64'h20, 64'h10, 32'd7, 16'h7777}, 1'b0,
                       QUIET});
    script.push_back('{'{ttlc_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 64'h20, 64'd0, 32'd0, 16'd0},
                       1'b0, QUIET});

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i])
      issue(script[i].req, $urandom_range(0, 19), script[i].typed, script[i].want);
    settle();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) settle();
      issue(draw_request(), ((i / BURST_SPAN) % 2 == 1) ? 0 : $urandom_range(0, 19),
            1'b0, QUIET);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
